/* hdl/tgr_pkg.sv */
`timescale 1ns / 1ps
package tgr_pkg;

  localparam int RAW_W      = 12;
  localparam int POS_W      = 12;
  localparam int LANES      = 5;
  localparam int SUM_W      = 14;
  localparam int PROD_W     = 24;
  localparam int QUO_W      = 13;
  localparam int REC_SHIFT  = 36;
  localparam int MIN_VALID  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RAW_W-1:0]  RAW_LO   = 12'd200;
  localparam logic [PROD_W-1:0] RAW_SPAN = 24'd3600;
  // floor(2^36 / 3600), estimate is low by at most one
  localparam logic [24:0]       REC_MUL  = 25'd19088743;
  // ceil(2^17 / 3), exact for dividends below 2^16
  localparam logic [16:0]       DIV3_MUL = 17'd43691;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_MOVE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_MIN  = 3'd5;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] tap_limit_ms;
    logic [8:0]  move_limit;
    logic [15:0] hold_ms;
    logic [8:0]  swipe_travel;
  } tgr_cfg_t;

  typedef struct packed {
    logic [31:0]      now_ms;
    logic             touched;
    logic             pos_ok;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
  } tgr_entry_t;

endpackage

/* hdl/tgr_front.sv */
`timescale 1ns / 1ps
module tgr_front #(
  parameter int SCREEN_W    = 320,
  parameter int SCREEN_H    = 240,
  parameter int NUM_SAMPLES = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           now_ms,
  input  logic                  touched,
  input  logic [2:0]            sample_count,
  input  logic [59:0]           sample_x_packed,
  input  logic [59:0]           sample_y_packed,
  input  logic [59:0]           sample_z_packed,
  input  logic [11:0]           pressure_min,
  output logic                  push_valid,
  input  logic                  push_ready,
  output tgr_pkg::tgr_entry_t   push_entry
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_SUM, F_DIV, F_MUL, F_REC, F_FIX, F_PUSH} fstate_t;

  localparam logic [1:0][RAW_W-1:0] AXIS_MAX = {RAW_W'(SCREEN_H - 1), RAW_W'(SCREEN_W - 1)};
  localparam logic [2:0] CNT_MAX = 3'(NUM_SAMPLES);

  fstate_t state;
  logic [31:0] now_r;
  logic        touched_r;
  logic [2:0]  count_r;
  logic [59:0] xs_r, ys_r, zs_r;
  logic        ok;
  logic [1:0]  mid;
  logic [SUM_W-1:0]  sum   [2];
  logic [RAW_W-1:0]  avg   [2];
  logic              low   [2];
  logic [PROD_W-1:0] prod  [2];
  logic [QUO_W-1:0]  qest  [2];
  logic [POS_W-1:0]  pos   [2];

  // combinational helpers
  logic [2:0]       cnt;
  logic [2:0]       nvalid;
  logic [LANES-1:0] lane_ok;
  logic [RAW_W-1:0] raw [2][LANES];
  logic [RAW_W-1:0] vmin [2], vmax [2];
  logic [SUM_W-1:0] vsum [2];
  logic [SUM_W-1:0] trim [2];
  logic [SUM_W-1:0] avg_c [2];
  logic [30:0]      div3 [2];
  logic [48:0]      rec [2];
  logic [PROD_W-1:0] back_mul [2], rem [2];
  logic [QUO_W:0]   quo [2];
  logic [POS_W-1:0] pos_c [2];

  always_comb begin
    cnt = (count_r > CNT_MAX) ? CNT_MAX : count_r;
    nvalid = '0;
    for (int i = 0; i < LANES; i++) begin
      raw[0][i] = xs_r[i*RAW_W +: RAW_W];
      raw[1][i] = ys_r[i*RAW_W +: RAW_W];
      lane_ok[i] = (3'(i) < cnt) && (zs_r[i*RAW_W +: RAW_W] > pressure_min);
      nvalid = nvalid + 3'(lane_ok[i]);
    end
    for (int a = 0; a < 2; a++) begin
      vmin[a] = '1;
      vmax[a] = '0;
      vsum[a] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (lane_ok[i]) begin
          if (raw[a][i] < vmin[a]) vmin[a] = raw[a][i];
          if (raw[a][i] > vmax[a]) vmax[a] = raw[a][i];
          vsum[a] = vsum[a] + SUM_W'(raw[a][i]);
        end
      end
      // middle values summed: drop one smallest and one largest
      trim[a] = vsum[a] - SUM_W'(vmin[a]) - SUM_W'(vmax[a]);
      div3[a] = sum[a] * DIV3_MUL;
      case (mid)
        2'd1:    avg_c[a] = sum[a];
        2'd2:    avg_c[a] = sum[a] >> 1;
        default: avg_c[a] = SUM_W'(div3[a] >> 17);
      endcase
      rec[a] = prod[a] * REC_MUL;
      back_mul[a] = PROD_W'(qest[a]) * RAW_SPAN;
      rem[a] = prod[a] - back_mul[a];
      quo[a] = {1'b0, qest[a]} + (QUO_W+1)'(rem[a] >= RAW_SPAN);
      if (low[a]) pos_c[a] = '0;
      else if (quo[a] > (QUO_W+1)'(AXIS_MAX[a])) pos_c[a] = POS_W'(AXIS_MAX[a]);
      else pos_c[a] = POS_W'(quo[a]);
    end
  end

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_entry = '{now_ms: now_r, touched: touched_r, pos_ok: ok, px: pos[0], py: pos[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            now_r     <= now_ms;
            touched_r <= touched;
            count_r   <= sample_count;
            xs_r      <= sample_x_packed;
            ys_r      <= sample_y_packed;
            zs_r      <= sample_z_packed;
            state     <= F_SUM;
          end
        end
        F_SUM: begin
          ok  <= (nvalid >= 3'(MIN_VALID)) && touched_r;
          mid <= (nvalid >= 3'(MIN_VALID)) ? 2'(nvalid - 3'd2) : 2'd1;
          for (int a = 0; a < 2; a++) sum[a] <= trim[a];
          state <= F_DIV;
        end
        F_DIV: begin
          for (int a = 0; a < 2; a++) avg[a] <= RAW_W'(avg_c[a]);
          state <= F_MUL;
        end
        F_MUL: begin
          for (int a = 0; a < 2; a++) begin
            low[a]  <= (avg[a] <= RAW_LO);
            prod[a] <= PROD_W'(avg[a] - RAW_LO) * PROD_W'(AXIS_MAX[a]);
          end
          state <= F_REC;
        end
        F_REC: begin
          for (int a = 0; a < 2; a++) qest[a] <= rec[a][REC_SHIFT +: QUO_W];
          state <= F_FIX;
        end
        F_FIX: begin
          for (int a = 0; a < 2; a++) pos[a] <= pos_c[a];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tgr_queue.sv */
`timescale 1ns / 1ps
module tgr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tgr_pkg::tgr_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tgr_pkg::tgr_entry_t pop_entry
);
  import tgr_pkg::*;

  tgr_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* hdl/tgr_back.sv */
`timescale 1ns / 1ps
module tgr_back (
  input  logic                clk,
  input  logic                rst,
  input  tgr_pkg::tgr_cfg_t   cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  tgr_pkg::tgr_entry_t pop_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          gesture,
  output logic [8:0]          pos_x,
  output logic [7:0]          pos_y,
  output logic [8:0]          swipe_dy
);
  import tgr_pkg::*;

  typedef enum logic [2:0] {G_NONE, G_TAP, G_LONG, G_UP, G_DOWN} gesture_t;

  logic             in_contact;
  logic [31:0]      press_start_time, last_event_time;
  logic [POS_W-1:0] start_x, start_y, latest_x, latest_y;

  logic             in_contact_next;
  logic [31:0]      press_start_next, last_event_next;
  logic [POS_W-1:0] start_x_next, start_y_next, latest_x_next, latest_y_next;
  gesture_t         g_next;
  logic [POS_W-1:0] ox_next, oy_next;
  logic [8:0]       dy_out_next;

  logic             open_window;
  logic [POS_W-1:0] lx, ly;
  logic signed [POS_W:0] ldx, ldy, rdx, rdy;
  logic [POS_W:0]   abs_ldx, abs_ldy, abs_rdx, abs_rdy;
  logic [31:0]      held;
  logic             fire;

  assign pop_ready = !out_valid || out_ready;
  assign fire      = pop_valid && pop_ready;

  always_comb begin
    open_window = (pop_entry.now_ms - last_event_time) >= {16'd0, cfg.debounce_ms};
    held = pop_entry.now_ms - press_start_time;
    lx = pop_entry.pos_ok ? pop_entry.px : latest_x;
    ly = pop_entry.pos_ok ? pop_entry.py : latest_y;
    // movement using this poll's position (held case)
    ldx = $signed({1'b0, lx}) - $signed({1'b0, start_x});
    ldy = $signed({1'b0, ly}) - $signed({1'b0, start_y});
    abs_ldx = ldx[POS_W] ? (POS_W+1)'(-ldx) : (POS_W+1)'(ldx);
    abs_ldy = ldy[POS_W] ? (POS_W+1)'(-ldy) : (POS_W+1)'(ldy);
    // movement using the stored position (release case)
    rdx = $signed({1'b0, latest_x}) - $signed({1'b0, start_x});
    rdy = $signed({1'b0, latest_y}) - $signed({1'b0, start_y});
    abs_rdx = rdx[POS_W] ? (POS_W+1)'(-rdx) : (POS_W+1)'(rdx);
    abs_rdy = rdy[POS_W] ? (POS_W+1)'(-rdy) : (POS_W+1)'(rdy);

    in_contact_next  = in_contact;
    press_start_next = press_start_time;
    last_event_next  = last_event_time;
    start_x_next     = start_x;
    start_y_next     = start_y;
    latest_x_next    = latest_x;
    latest_y_next    = latest_y;
    g_next           = G_NONE;
    ox_next          = '0;
    oy_next          = '0;
    dy_out_next      = '0;

    if (open_window) begin
      if (pop_entry.touched && !in_contact) begin
        if (pop_entry.pos_ok) begin
          start_x_next     = pop_entry.px;
          latest_x_next    = pop_entry.px;
          start_y_next     = pop_entry.py;
          latest_y_next    = pop_entry.py;
          press_start_next = pop_entry.now_ms;
          in_contact_next  = 1'b1;
        end
      end else if (pop_entry.touched && in_contact) begin
        latest_x_next = lx;
        latest_y_next = ly;
        if (held >= {16'd0, cfg.hold_ms} &&
            abs_ldx < (POS_W+1)'(cfg.move_limit) &&
            abs_ldy < (POS_W+1)'(cfg.move_limit)) begin
          g_next          = G_LONG;
          ox_next         = lx;
          oy_next         = ly;
          in_contact_next = 1'b0;
          last_event_next = pop_entry.now_ms;
        end
      end else if (!pop_entry.touched && in_contact) begin
        in_contact_next = 1'b0;
        last_event_next = pop_entry.now_ms;
        if (abs_rdy >= (POS_W+1)'(cfg.swipe_travel) && abs_rdy > abs_rdx) begin
          g_next  = rdy[POS_W] ? G_UP : G_DOWN;
          ox_next = start_x;
          oy_next = start_y;
          if (rdy > 13'sd255) dy_out_next = 9'd255;
          else if (rdy < -13'sd256) dy_out_next = 9'h100;
          else dy_out_next = 9'(rdy);
        end else if (held <= {16'd0, cfg.tap_limit_ms} &&
                     abs_rdx < (POS_W+1)'(cfg.move_limit) &&
                     abs_rdy < (POS_W+1)'(cfg.move_limit)) begin
          g_next  = G_TAP;
          ox_next = start_x;
          oy_next = start_y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      in_contact       <= 1'b0;
      press_start_time <= '0;
      last_event_time  <= '0;
      start_x          <= '0;
      start_y          <= '0;
      latest_x         <= '0;
      latest_y         <= '0;
    end else begin
      if (fire) begin
        out_valid        <= 1'b1;
        in_contact       <= in_contact_next;
        press_start_time <= press_start_next;
        last_event_time  <= last_event_next;
        start_x          <= start_x_next;
        start_y          <= start_y_next;
        latest_x         <= latest_x_next;
        latest_y         <= latest_y_next;
        gesture          <= g_next;
        pos_x            <= 9'(ox_next);
        pos_y            <= 8'(oy_next);
        swipe_dy         <= dy_out_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/touch_gesture_recognizer.sv */
`timescale 1ns / 1ps
// the front end takes a new poll word only once its filter and map sequence has handed
// the previous word to the queue; the back end settles one word per cycle from a
// two-word queue while its output is not stalled, so short output stalls never reach
// the input; reset: synchronous, active high; clears contact state, timers and queue,
// loads register defaults
module touch_gesture_recognizer #(
  parameter int SCREEN_W    = 320,
  parameter int SCREEN_H    = 240,
  parameter int NUM_SAMPLES = 5
) (
  input  logic        clk,
  input  logic        rst,
  // poll words in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_ms,
  input  logic        touched,
  input  logic [2:0]  sample_count,
  input  logic [59:0] sample_x_packed,
  input  logic [59:0] sample_y_packed,
  input  logic [59:0] sample_z_packed,
  // gesture words out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  gesture,
  output logic [8:0]  pos_x,
  output logic [7:0]  pos_y,
  output logic [8:0]  swipe_dy,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tgr_pkg::*;

  tgr_cfg_t    cfg;
  logic [11:0] pressure_min;
  logic        q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  tgr_entry_t  q_push_entry, q_pop_entry;

  // register file, always ready; unchecked: write only while no poll is in flight
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= 16'd50;
      cfg.tap_limit_ms <= 16'd400;
      cfg.move_limit   <= 9'd12;
      cfg.hold_ms      <= 16'd800;
      cfg.swipe_travel <= 9'd20;
      pressure_min     <= 12'd50;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_ms  <= cfg_data;
        REG_TAP_MAX_MS: cfg.tap_limit_ms <= cfg_data;
        REG_TAP_MOVE:   cfg.move_limit   <= cfg_data[8:0];
        REG_LONG_PRESS: cfg.hold_ms      <= cfg_data;
        REG_SWIPE_MIN:  cfg.swipe_travel <= cfg_data[8:0];
        REG_PRESS_MIN:  pressure_min     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // front end: pressure filter, trimmed mean and screen mapping
  tgr_front #(
    .SCREEN_W   (SCREEN_W),
    .SCREEN_H   (SCREEN_H),
    .NUM_SAMPLES(NUM_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .now_ms         (now_ms),
    .touched        (touched),
    .sample_count   (sample_count),
    .sample_x_packed(sample_x_packed),
    .sample_y_packed(sample_y_packed),
    .sample_z_packed(sample_z_packed),
    .pressure_min   (pressure_min),
    .push_valid     (q_push_valid),
    .push_ready     (q_push_ready),
    .push_entry     (q_push_entry)
  );

  // two-word queue decouples the filter from the gesture tracker
  tgr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_entry(q_push_entry),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_entry (q_pop_entry)
  );

  // back end: debounce, contact tracking and gesture decision
  tgr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_valid(q_pop_valid),
    .pop_ready(q_pop_ready),
    .pop_entry(q_pop_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .gesture  (gesture),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .swipe_dy (swipe_dy)
  );

endmodule

/* verif/touch_gesture_recognizer_tb.sv */
`timescale 1ns / 1ps
module touch_gesture_recognizer_tb;
  import tgr_pkg::*;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int NSAMP = 5;
  localparam int CYCLE_LIMIT = 1500000;

  typedef enum logic [2:0] {
    G_NONE = 3'd0, G_TAP = 3'd1, G_LONG = 3'd2, G_SWIPE_UP = 3'd3, G_SWIPE_DOWN = 3'd4
  } gesture_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        touched;
    logic [2:0]  cnt;
    logic [59:0] xs;
    logic [59:0] ys;
    logic [59:0] zs;
  } poll_t;

  localparam int POLL_W = $bits(poll_t);

  typedef struct packed {
    logic [2:0] gesture;
    logic [8:0] pos_x;
    logic [7:0] pos_y;
    logic [8:0] swipe_dy;
  } event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [31:0] now_ms = '0;
  logic touched = 1'b0;
  logic [2:0] sample_count = '0;
  logic [59:0] sample_x_packed = '0, sample_y_packed = '0, sample_z_packed = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] gesture;
  logic [8:0] pos_x;
  logic [7:0] pos_y;
  logic [8:0] swipe_dy;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  touch_gesture_recognizer u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and gesture state
  logic [15:0] m_debounce, m_tap_ms, m_long_ms;
  logic [8:0]  m_tap_move, m_swipe_min;
  logic [11:0] m_press_min;
  bit          m_contact;
  logic [31:0] m_press_t, m_event_t;
  int          m_sx, m_sy, m_lx, m_ly;

  poll_t  poll_q[$];
  event_t gesture_q[$];
  int     mismatches = 0;
  int     words_out = 0;
  int     n_gest[5];
  longint cycles = 0;
  bit     hold_out = 1'b0;
  bit     driver_pause = 1'b0;

  function automatic int map_axis(int raw, int size);
    int v;
    if (raw <= 200) return 0;
    v = (raw - 200) * (size - 1) / 3600;
    if (v > size - 1) v = size - 1;
    return v;
  endfunction

  // trimmed mean of the valid samples; returns 0 when too few are usable
  function automatic bit trimmed_pos(poll_t p, output int px, output int py);
    int xa[5], ya[5];
    int n, c, t, sx, sy, k;
    n = 0; sx = 0; sy = 0;
    c = (p.cnt > NSAMP) ? NSAMP : p.cnt;
    for (int i = 0; i < c; i++)
      if (p.zs[12*i +: 12] > m_press_min) begin
        xa[n] = p.xs[12*i +: 12];
        ya[n] = p.ys[12*i +: 12];
        n++;
      end
    px = 0; py = 0;
    if (n < 3) return 1'b0;
    for (int i = 1; i < n; i++)
      for (k = i; k > 0; k--) begin
        if (xa[k-1] > xa[k]) begin t = xa[k]; xa[k] = xa[k-1]; xa[k-1] = t; end
        if (ya[k-1] > ya[k]) begin t = ya[k]; ya[k] = ya[k-1]; ya[k-1] = t; end
      end
    for (int i = 1; i <= n - 2; i++) begin
      sx += xa[i];
      sy += ya[i];
    end
    px = map_axis(sx / (n - 2), SCR_W);
    py = map_axis(sy / (n - 2), SCR_H);
    return 1'b1;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic event_t next_gesture(poll_t p);
    event_t e;
    int px, py, dx, dy, ody;
    logic [31:0] dur;
    e = '0;
    if (p.now_ms - m_event_t >= {16'd0, m_debounce}) begin
      if (p.touched && !m_contact) begin
        if (trimmed_pos(p, px, py)) begin
          m_sx = px; m_lx = px; m_sy = py; m_ly = py;
          m_press_t = p.now_ms;
          m_contact = 1'b1;
        end
      end else if (p.touched) begin
        if (trimmed_pos(p, px, py)) begin m_lx = px; m_ly = py; end
        if (p.now_ms - m_press_t >= {16'd0, m_long_ms}) begin
          dx = iabs(m_lx - m_sx);
          dy = iabs(m_ly - m_sy);
          if (dx < m_tap_move && dy < m_tap_move) begin
            e.gesture = G_LONG; e.pos_x = 9'(m_lx); e.pos_y = 8'(m_ly);
            m_contact = 1'b0;
            m_event_t = p.now_ms;
          end
        end
      end else if (m_contact) begin
        dur = p.now_ms - m_press_t;
        m_contact = 1'b0;
        m_event_t = p.now_ms;
        dx = m_lx - m_sx;
        dy = m_ly - m_sy;
        if (iabs(dy) >= m_swipe_min && iabs(dy) > iabs(dx)) begin
          e.gesture = dy < 0 ? G_SWIPE_UP : G_SWIPE_DOWN;
          e.pos_x = 9'(m_sx); e.pos_y = 8'(m_sy);
          ody = dy > 255 ? 255 : (dy < -256 ? -256 : dy);
          e.swipe_dy = 9'(ody);
        end else if (dur <= m_tap_ms && iabs(dx) < m_tap_move && iabs(dy) < m_tap_move) begin
          e.gesture = G_TAP; e.pos_x = 9'(m_sx); e.pos_y = 8'(m_sy);
        end
      end
    end
    return e;
  endfunction

  function automatic int short_or_long_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: feeds poll words from the queue, with random gaps
  int gap_in = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        n_gest[0] = n_gest[0];
        gesture_q.push_back(next_gesture(poll_q.pop_front()));
      end
      if ((in_valid && !in_ready)) begin
        // hold the word until taken
      end else if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_valid <= 1'b0;
      end else if (poll_q.size() != 0 && !driver_pause &&
                   !(in_valid && in_ready && poll_q.size() == 0)) begin
        in_valid <= 1'b1;
        {now_ms, touched, sample_count, sample_x_packed, sample_y_packed,
         sample_z_packed} <= poll_q[0];
        gap_in <= short_or_long_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure and comparison with the oldest expectation
  int gap_out = 0;
  always @(posedge clk) begin
    event_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {gesture, pos_x, pos_y, swipe_dy};
        words_out++;
        if (gesture_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected gesture word %p", got);
        end else begin
          want = gesture_q.pop_front();
          if (want.gesture <= G_SWIPE_DOWN) n_gest[want.gesture]++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: gesture %0d/%0d x %0d/%0d y %0d/%0d dy %0d/%0d (exp/act)",
                       want.gesture, got.gesture, want.pos_x, got.pos_x, want.pos_y,
                       got.pos_y, $signed(want.swipe_dy), $signed(got.swipe_dy));
          end
        end
      end
      if (hold_out) out_ready <= 1'b0;
      else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        gap_out <= short_or_long_gap();
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("touch_gesture_recognizer_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE:   m_debounce  = val;
      REG_TAP_MAX_MS: m_tap_ms    = val;
      REG_TAP_MOVE:   m_tap_move  = val[8:0];
      REG_LONG_PRESS: m_long_ms   = val;
      REG_SWIPE_MIN:  m_swipe_min = val[8:0];
      REG_PRESS_MIN:  m_press_min = val[11:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (poll_q.size() != 0 || gesture_q.size() != 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // raw value placed around a screen coordinate, with a little noise
  function automatic logic [11:0] raw_for(int pix, int size);
    int r;
    r = 200 + (pix * 3600) / (size - 1) + $urandom_range(0, 15);
    return r > 4095 ? 12'hfff : r[11:0];
  endfunction

  logic [31:0] clock_ms;

  task automatic add_poll(bit t, int px, int py, int nvalid);
    poll_t p;
    p.now_ms = clock_ms;
    p.touched = t;
    p.cnt = 3'd5;
    p.xs = '0; p.ys = '0; p.zs = '0;
    for (int i = 0; i < 5; i++) begin
      p.xs[12*i +: 12] = raw_for(px + $urandom_range(0, 2), SCR_W);
      p.ys[12*i +: 12] = raw_for(py + $urandom_range(0, 2), SCR_H);
      p.zs[12*i +: 12] = (i < nvalid) ? 12'(12'd600 + $urandom_range(0, 3000))
                                      : 12'($urandom_range(0, m_press_min));
    end
    poll_q.push_back(p);
  endtask

  task automatic add_noise();
    poll_t p;
    p = POLL_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    p.now_ms = clock_ms;
    poll_q.push_back(p);
  endtask

  // one gesture: press, hold or move, release
  task automatic add_gesture_seq();
    int x0, y0, kind, steps, dy;
    x0 = $urandom_range(0, SCR_W - 1);
    y0 = $urandom_range(0, SCR_H - 1);
    kind = $urandom_range(0, 3);
    steps = $urandom_range(1, 5);
    dy = (kind == 2) ? $urandom_range(0, 200) - 100 : $urandom_range(0, 6);
    clock_ms += m_debounce + $urandom_range(0, 40);
    add_poll(1'b1, x0, y0, $urandom_range(3, 5));
    for (int i = 1; i <= steps; i++) begin
      clock_ms += (kind == 1) ? $urandom_range(100, 400) : $urandom_range(5, 60);
      add_poll(1'b1, x0, (y0 + dy * i / steps) < 0 ? 0 :
               ((y0 + dy * i / steps) > SCR_H - 1 ? SCR_H - 1 : y0 + dy * i / steps),
               $urandom_range(0, 9) == 0 ? 2 : 5);
    end
    clock_ms += $urandom_range(1, 30);
    add_poll(1'b0, 0, 0, 0);
  endtask

  initial begin
    int r;
    m_debounce = 50; m_tap_ms = 400; m_tap_move = 12;
    m_long_ms = 800; m_swipe_min = 20; m_press_min = 50;
    m_contact = 1'b0; m_press_t = '0; m_event_t = '0;
    m_sx = 0; m_sy = 0; m_lx = 0; m_ly = 0;
    clock_ms = 32'd100;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: tap, long press, swipes, edge raws, too few samples, debounce
    add_poll(1'b1, 100, 100, 5); clock_ms += 50;
    add_poll(1'b0, 0, 0, 0);     clock_ms += 10;
    add_poll(1'b1, 10, 10, 5);   clock_ms += 20;   // inside the debounce window
    clock_ms += 100;
    add_poll(1'b1, 0, 0, 3);     clock_ms += 900;
    add_poll(1'b1, 0, 0, 2);     clock_ms += 100;  // long press on old position
    add_poll(1'b1, 319, 239, 5); clock_ms += 100;
    add_poll(1'b1, 319, 100, 5); clock_ms += 30;
    add_poll(1'b0, 0, 0, 0);     clock_ms += 100;
    add_poll(1'b1, 160, 10, 5);  clock_ms += 30;
    add_poll(1'b1, 160, 230, 5); clock_ms += 30;
    add_poll(1'b0, 0, 0, 0);     clock_ms += 100;
    add_poll(1'b1, 50, 50, 1);   clock_ms += 100;
    begin
      poll_t p;
      p = '0; p.now_ms = clock_ms; p.touched = 1'b1; p.cnt = 3'd7;
      p.xs = '1; p.ys = '0; p.zs = '1;
      poll_q.push_back(p); clock_ms += 100;
      p.now_ms = clock_ms; p.touched = 1'b0; p.xs = '0; p.ys = '1;
      poll_q.push_back(p); clock_ms += 100;
    end
    // time wrap
    clock_ms = 32'hffff_fff0;
    add_poll(1'b1, 30, 30, 4); clock_ms += 40;
    add_poll(1'b0, 0, 0, 0);   clock_ms += 100;

    // receiver stalls long while polls keep coming
    hold_out = 1'b1;
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DEBOUNCE, 16'd0); write_reg(REG_TAP_MAX_MS, 16'hffff);
          write_reg(REG_TAP_MOVE, 16'd511); write_reg(REG_LONG_PRESS, 16'd0);
          write_reg(REG_SWIPE_MIN, 16'd0); write_reg(REG_PRESS_MIN, 16'd0);
        end
        1: begin
          write_reg(REG_DEBOUNCE, 16'hffff); write_reg(REG_TAP_MAX_MS, 16'd0);
          write_reg(REG_TAP_MOVE, 16'd0); write_reg(REG_LONG_PRESS, 16'hffff);
          write_reg(REG_SWIPE_MIN, 16'd511); write_reg(REG_PRESS_MIN, 16'hfff);
        end
        default: begin
          write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 80)));
          write_reg(REG_TAP_MAX_MS, 16'($urandom_range(100, 600)));
          write_reg(REG_TAP_MOVE, 16'($urandom_range(3, 40)));
          write_reg(REG_LONG_PRESS, 16'($urandom_range(200, 1000)));
          write_reg(REG_SWIPE_MIN, 16'($urandom_range(5, 60)));
          write_reg(REG_PRESS_MIN, 16'($urandom_range(0, 400)));
        end
      endcase
      while (poll_q.size() < 275) begin
        r = $urandom_range(0, 9);
        if (r < 8) add_gesture_seq();
        else begin
          clock_ms += $urandom_range(0, 2000);
          add_noise();
        end
      end
      if (ph == 3) begin
        // sender waits for every outstanding result midway
        while (poll_q.size() > 140) @(posedge clk);
        driver_pause = 1'b1;
        while (gesture_q.size() != 0 || in_valid) @(posedge clk);
        driver_pause = 1'b0;
      end
      drain();
    end

    $display("polls checked: %0d; none %0d tap %0d long %0d up %0d down %0d",
             words_out, n_gest[0], n_gest[1], n_gest[2], n_gest[3], n_gest[4]);
    $display("register extremes and four random settings exercised");
    if (mismatches == 0 && gesture_q.size() == 0)
      $display("touch_gesture_recognizer_tb: PASS");
    else
      $display("touch_gesture_recognizer_tb: FAIL");
    $finish;
  end

endmodule
